FILE: rtl/core/utf8_decoder_three_byte_assert.svh
// ---------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Concurrent assertion wrappers; all of them compile away under NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef UTF8_DECODER_THREE_BYTE_ASSERT_SVH
`define UTF8_DECODER_THREE_BYTE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every edge outside reset
`define U8D_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// when trig holds, prop must hold at the next edge
`define U8D_ASSERT_NEXT(lbl, clk, rst, trig, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`else

`define U8D_ASSERT(lbl, clk, rst, prop, msg)
`define U8D_ASSERT_NEXT(lbl, clk, rst, trig, prop, msg)

`endif

`endif

FILE: rtl/core/u8d_pkg.sv
// ---------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the three-byte UTF-8 decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

   // replacement code after reset: '?'
   localparam logic [15:0] REPLACEMENT_RESET = 16'h003F;

   // results one byte can cause
   localparam int MAX_RESULTS = 3;
   localparam int SLOT_W      = $clog2(MAX_RESULTS + 1);

   // bundle queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // bytes held of an unfinished sequence
   typedef enum logic [1:0] {
      HOLD_NONE = 2'd0,
      HOLD_ONE  = 2'd1,
      HOLD_TWO  = 2'd2
   } held_state_type;

   // one result; a replacement takes its code from the register at the back end
   typedef struct packed {
      logic [15:0] code;
      logic        rep;
   } result_type;

   // all results of one byte, slot 0 first
   typedef struct packed {
      logic [SLOT_W-1:0]                count;
      result_type [MAX_RESULTS-1:0]     slot;
   } bundle_type;

endpackage

`default_nettype wire

FILE: rtl/core/u8d_front.sv
// ---------------------------------------------------------------------------
// u8d_front
// Accepts text bytes, tracks the pending sequence and builds a bundle of
// up to three results per byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_decoder_three_byte_assert.svh"

module u8d_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [7:0]          in_byte,
   input  wire logic                in_last,
   input  wire logic                space,
   output logic                     in_ready,
   output logic                     push,
   output u8d_pkg::bundle_type      push_data
);

   localparam int SLOT_W_L = u8d_pkg::SLOT_W;

   u8d_pkg::held_state_type state_ff, state_in, mid_state;
   logic [7:0] held_lead_ff, held_lead_in;
   logic [7:0] held_second_ff, held_second_in;

   logic accept;
   logic byte_zero, byte_cont, byte_ascii, byte_lead;
   logic held_is_two_byte;
   logic takes_lead;
   logic [SLOT_W_L-1:0] pre_reps, post_reps;

   u8d_pkg::bundle_type bundle;

   // append one result if a slot is left
   function automatic u8d_pkg::bundle_type add_result(u8d_pkg::bundle_type b,
                                                      u8d_pkg::result_type r);
      u8d_pkg::bundle_type o;
      o = b;
      if (o.count < SLOT_W_L'(u8d_pkg::MAX_RESULTS)) begin
         o.slot[o.count[SLOT_W_L-1:0]] = r;
         o.count = o.count + SLOT_W_L'(1);
      end
      return o;
   endfunction

   function automatic logic [SLOT_W_L-1:0] held_bytes(u8d_pkg::held_state_type s);
      logic [SLOT_W_L-1:0] n;
      n = '0;
      unique case (s)
         u8d_pkg::HOLD_ONE: n = SLOT_W_L'(1);
         u8d_pkg::HOLD_TWO: n = SLOT_W_L'(2);
         default:           n = '0;
      endcase
      return n;
   endfunction

   assign in_ready = space;
   assign accept   = in_valid && space;

   // byte classes
   assign byte_zero        = (in_byte == 8'h00);
   assign byte_cont        = (in_byte[7:6] == 2'b10);
   assign byte_ascii       = !in_byte[7];
   assign byte_lead        = (in_byte[7:5] == 3'b110) || (in_byte[7:4] == 4'b1110);
   assign held_is_two_byte = (held_lead_ff[7:5] == 3'b110);

   // byte is taken as a new lead (nothing held, or the held sequence broke)
   assign takes_lead = !byte_zero && ((state_ff == u8d_pkg::HOLD_NONE) || !byte_cont);

   // next state: after the byte, then the end-of-string flush
   always_comb begin
      mid_state = u8d_pkg::HOLD_NONE;
      if (takes_lead) begin
         mid_state = byte_lead ? u8d_pkg::HOLD_ONE : u8d_pkg::HOLD_NONE;
      end else if (!byte_zero) begin
         unique case (state_ff)
            u8d_pkg::HOLD_ONE: mid_state = held_is_two_byte ? u8d_pkg::HOLD_NONE
                                                            : u8d_pkg::HOLD_TWO;
            default:           mid_state = u8d_pkg::HOLD_NONE;
         endcase
      end
      state_in = state_ff;
      if (accept) begin
         state_in = (byte_zero || in_last) ? u8d_pkg::HOLD_NONE : mid_state;
      end
   end

   // held bytes
   always_comb begin
      held_lead_in   = held_lead_ff;
      held_second_in = held_second_ff;
      if (accept && takes_lead && byte_lead) begin
         held_lead_in = in_byte;
      end
      if (accept && !byte_zero && byte_cont && (state_ff == u8d_pkg::HOLD_ONE)) begin
         held_second_in = in_byte;
      end
   end

   // result bundle: flushed reps, the byte's own result, end-of-string reps
   always_comb begin
      bundle    = '0;
      pre_reps  = (byte_zero || takes_lead) ? held_bytes(state_ff) : '0;
      post_reps = (in_last && !byte_zero) ? held_bytes(mid_state) : '0;
      if (pre_reps >= SLOT_W_L'(1)) bundle = add_result(bundle, '{code: 16'h0, rep: 1'b1});
      if (pre_reps >= SLOT_W_L'(2)) bundle = add_result(bundle, '{code: 16'h0, rep: 1'b1});
      if (takes_lead) begin
         if (byte_ascii) begin
            bundle = add_result(bundle, '{code: {8'h00, in_byte}, rep: 1'b0});
         end else if (!byte_lead) begin
            bundle = add_result(bundle, '{code: 16'h0, rep: 1'b1});
         end
      end else if (!byte_zero) begin
         if ((state_ff == u8d_pkg::HOLD_ONE) && held_is_two_byte) begin
            bundle = add_result(bundle,
               '{code: {5'b0, held_lead_ff[4:0], in_byte[5:0]}, rep: 1'b0});
         end else if (state_ff == u8d_pkg::HOLD_TWO) begin
            bundle = add_result(bundle,
               '{code: {held_lead_ff[3:0], held_second_ff[5:0], in_byte[5:0]}, rep: 1'b0});
         end
      end
      if (post_reps >= SLOT_W_L'(1)) bundle = add_result(bundle, '{code: 16'h0, rep: 1'b1});
      if (post_reps >= SLOT_W_L'(2)) bundle = add_result(bundle, '{code: 16'h0, rep: 1'b1});
   end

   assign push      = accept && (bundle.count != '0);
   assign push_data = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= u8d_pkg::HOLD_NONE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      held_lead_ff   <= held_lead_in;
      held_second_ff <= held_second_in;
   end

   // a zero byte always leaves nothing pending
   `U8D_ASSERT_NEXT(a_zero_flushes, clock, reset, accept && byte_zero,
      state_ff == u8d_pkg::HOLD_NONE, "zero byte left bytes pending")
   // two held bytes only ever follow a three-byte lead
   `U8D_ASSERT(a_two_held_lead, clock, reset,
      (state_ff != u8d_pkg::HOLD_TWO) || (held_lead_ff[7:4] == 4'b1110),
      "two bytes held behind a non three-byte lead")

endmodule

`default_nettype wire

FILE: rtl/core/u8d_queue.sv
// ---------------------------------------------------------------------------
// u8d_queue
// Short bundle queue decoupling the front from the output side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_decoder_three_byte_assert.svh"

module u8d_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire u8d_pkg::bundle_type push_data,
   input  wire logic                pop,
   output logic                     not_full,
   output logic                     head_valid,
   output u8d_pkg::bundle_type      head_data
);

   localparam int PTR_W = u8d_pkg::QUEUE_PTR_W;
   localparam int CNT_W = u8d_pkg::QUEUE_CNT_W;

   u8d_pkg::bundle_type entry_ff [u8d_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_full   = (count_ff != CNT_W'(u8d_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(u8d_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(u8d_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `U8D_ASSERT(a_no_overflow, clock, reset, !push || not_full,
      "bundle pushed into a full queue")
   `U8D_ASSERT(a_no_underflow, clock, reset, !pop || head_valid,
      "bundle popped from an empty queue")

endmodule

`default_nettype wire

FILE: rtl/core/u8d_emit.sv
// ---------------------------------------------------------------------------
// u8d_emit
// Unrolls queued bundles into single results through the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_decoder_three_byte_assert.svh"

module u8d_emit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire u8d_pkg::bundle_type head_data,
   input  wire logic [15:0]         replacement_code,
   input  wire logic                out_ready,
   output logic                     pop,
   output logic                     out_valid,
   output logic [15:0]              out_code,
   output logic                     out_rep,
   output logic                     out_last
);

   localparam int SLOT_W = u8d_pkg::SLOT_W;

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [15:0]       code_ff, code_in;
   logic              rep_ff, rep_in;
   logic              last_ff, last_in;

   logic                load;
   logic                final_slot;
   u8d_pkg::result_type sel;

   assign load       = head_valid && (!valid_ff || out_ready);
   assign final_slot = (idx_ff == (head_data.count - SLOT_W'(1)));
   assign sel        = head_data.slot[idx_ff];
   assign pop        = load && final_slot;

   // slot walk and output register
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      code_in  = code_ff;
      rep_in   = rep_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = final_slot ? '0 : idx_ff + SLOT_W'(1);
         valid_in = 1'b1;
         code_in  = sel.rep ? replacement_code : sel.code;
         rep_in   = sel.rep;
         last_in  = final_slot;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      rep_ff  <= rep_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_code  = code_ff;
   assign out_rep   = rep_ff;
   assign out_last  = last_ff;

   `U8D_ASSERT(a_slot_in_range, clock, reset,
      !head_valid || (idx_ff < head_data.count), "slot index beyond bundle")

endmodule

`default_nettype wire

FILE: rtl/core/utf8_decoder_three_byte.sv
// ---------------------------------------------------------------------------
// utf8_decoder_three_byte
// Streaming UTF-8 decoder for one-, two- and three-byte sequences with a
// programmable replacement code.
// ---------------------------------------------------------------------------
//  channel  | ports        | contents
//  ---------+--------------+---------------------------------------------
//  request  | req_t*       | text byte, end-of-string mark in tlast
//  response | rsp_t*       | code point, replacement flag, last of run
//  csr      | csr_wr_*     | replacement code, write only
//
//  One byte accepted per cycle while the two-entry bundle queue has room.
//  Results leave one per cycle from the output register while rsp_tready is
//  high; a byte giving two or three results leaves them one after another.
//  A byte's results are registered in the bundle queue and then in the
//  output register before the first of them can be taken.
//  Reset clears pending bytes, the queue and the output; code becomes '?'.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_decoder_three_byte (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,   // replacement_code
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // [7:0] text_byte
   input  wire logic        req_tlast,     // end_of_string
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,     // [15:0] code_point
   output logic             rsp_tuser,     // [0] is_replacement
   output logic             rsp_tlast      // last_of_run
);

   logic [15:0] repl_code_ff, repl_code_in;

   logic                push, pop, not_full, head_valid;
   u8d_pkg::bundle_type push_data, head_data;

   // replacement code register
   assign repl_code_in = csr_wr_en ? csr_wr_data : repl_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_code_ff <= u8d_pkg::REPLACEMENT_RESET;
      end else begin
         repl_code_ff <= repl_code_in;
      end
   end

   u8d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .space     (not_full),
      .in_ready  (req_tready),
      .push      (push),
      .push_data (push_data)
   );

   u8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .not_full   (not_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   u8d_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_data        (head_data),
      .replacement_code (repl_code_ff),
      .out_ready        (rsp_tready),
      .pop              (pop),
      .out_valid        (rsp_tvalid),
      .out_code         (rsp_tdata),
      .out_rep          (rsp_tuser),
      .out_last         (rsp_tlast)
   );

endmodule

`default_nettype wire
